// ===== hw/rtl/range_add_range_sum_tree_core_macros.svh =====
// assertion macros for the range add range sum tree core
`ifndef RANGE_ADD_RANGE_SUM_TREE_CORE_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_TREE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RARST_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define RARST_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RARST_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define RARST_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/rarst_pkg.sv =====
// shared types and constants of the range add range sum tree core
`default_nettype none
package rarst_pkg;
   localparam int POS_W  = 11;
   localparam int VAL_W  = 16;
   localparam int SUM_W  = 48;
   localparam int PEND_W = 32;
   localparam int ACC_W  = 64;

   // request operation codes
   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_SUM = 1'b1;

   // node read select
   typedef enum logic [1:0] {
      RD_SELF,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   // controller to datapath commands
   typedef struct packed {
      logic       clear;
      logic       capture;
      logic       descend;
      logic       sibling;
      logic       ascend;
      rd_sel_type rd_sel;
      logic       prod_full;
      logic       prod_part;
      logic       prod_fix;
      logic       acc_add;
      logic       wr_pend;
      logic       wr_cs;
      logic       rsp_load;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic empty;
      logic disjoint;
      logic full;
      logic is_root;
      logic is_right;
      logic is_query;
      logic clr_last;
   } status_type;
endpackage
`default_nettype wire

// ===== hw/rtl/range_add_range_sum_tree_core.sv =====
// top level of the range add range sum tree core
// one request at a time; an empty range goes from the start state straight to the done state
// other requests visit up to about 4 nodes per level over log2(LEAVES)+1 levels, with node
// reads and writes in separate states, set by the single read and write port of the node store
// synchronous reset, then a clearing pass over all 2*LEAVES node entries with req_ready low
`default_nettype none
`include "range_add_range_sum_tree_core_macros.svh"
module range_add_range_sum_tree_core #(
   parameter int LEAVES = 1024
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_func,
   input  wire [rarst_pkg::POS_W-1:0]         req_range_start,
   input  wire [rarst_pkg::POS_W-1:0]         req_range_end,
   input  wire signed [rarst_pkg::VAL_W-1:0]  req_add_value,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic signed [rarst_pkg::SUM_W-1:0] rsp_range_sum,
   output logic                               rsp_overflow
);
   import rarst_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer
   rarst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // node store and arithmetic
   rarst_datapath #(
      .LEAVES (LEAVES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .req_add_value   (req_add_value),
      .cmd             (cmd),
      .status          (status),
      .rsp_range_sum   (rsp_range_sum),
      .rsp_overflow    (rsp_overflow)
   );

   // checks
   `RARST_ASSERT_NEXT(a_one_request, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")
   `RARST_ASSERT_NOW(a_clear_blocks, clock, reset, cmd.clear, !req_ready, "request taken during clearing pass")
   `RARST_ASSERT_NOW(a_one_move, clock, reset, 1'b1, $onehot0({cmd.descend, cmd.sibling, cmd.ascend}), "conflicting tree moves")
   `RARST_ASSERT_NOW(a_one_write, clock, reset, 1'b1, !(cmd.wr_pend && cmd.wr_cs), "two node writes at once")
endmodule
`default_nettype wire

// ===== hw/rtl/rarst_ctrl.sv =====
// controller state machine that walks the tree for one request
`default_nettype none
module rarst_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  wire rarst_pkg::status_type status,
   output rarst_pkg::cmd_type    cmd
);
   import rarst_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_VISIT,
      ST_FULL_RD,
      ST_FULL_ACC,
      ST_PART_RD,
      ST_PART_ACC,
      ST_RET,
      ST_FIX_L,
      ST_FIX_R,
      ST_FIX_S,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_SELF;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            state_in = status.empty ? ST_DONE : ST_VISIT;
         end
         ST_VISIT: begin
            if (status.disjoint) begin
               state_in = ST_RET;
            end else if (status.full) begin
               state_in = ST_FULL_RD;
            end else if (status.is_query) begin
               state_in = ST_PART_RD;
            end else begin
               cmd.descend = 1'b1;
            end
         end
         ST_FULL_RD: begin
            if (status.is_query) begin
               cmd.prod_full = 1'b1;
               state_in      = ST_FULL_ACC;
            end else begin
               cmd.wr_pend = 1'b1;
               state_in    = ST_RET;
            end
         end
         ST_FULL_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_RET;
         end
         ST_PART_RD: begin
            cmd.prod_part = 1'b1;
            state_in      = ST_PART_ACC;
         end
         ST_PART_ACC: begin
            cmd.acc_add = 1'b1;
            cmd.descend = 1'b1;
            state_in    = ST_VISIT;
         end
         ST_RET: begin
            if (status.is_root) begin
               state_in = ST_DONE;
            end else if (status.is_right) begin
               cmd.ascend = 1'b1;
               state_in   = status.is_query ? ST_RET : ST_FIX_L;
            end else begin
               cmd.sibling = 1'b1;
               state_in    = ST_VISIT;
            end
         end
         ST_FIX_L: begin
            cmd.rd_sel = RD_LEFT;
            state_in   = ST_FIX_R;
         end
         ST_FIX_R: begin
            cmd.rd_sel   = RD_RIGHT;
            cmd.prod_fix = 1'b1;
            state_in     = ST_FIX_S;
         end
         ST_FIX_S: begin
            cmd.wr_cs = 1'b1;
            state_in  = ST_RET;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // response valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/rarst_datapath.sv =====
// node memories, tree navigation and arithmetic
`default_nettype none
module rarst_datapath #(
   parameter int LEAVES = 1024
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_func,
   input  wire [rarst_pkg::POS_W-1:0]           req_range_start,
   input  wire [rarst_pkg::POS_W-1:0]           req_range_end,
   input  wire signed [rarst_pkg::VAL_W-1:0]    req_add_value,
   input  wire rarst_pkg::cmd_type              cmd,
   output rarst_pkg::status_type                status,
   output logic signed [rarst_pkg::SUM_W-1:0]   rsp_range_sum,
   output logic                                 rsp_overflow
);
   import rarst_pkg::*;

   localparam int LOG   = $clog2(LEAVES);
   localparam int NODES = 2 * LEAVES;
   localparam int NB    = LOG + 1;
   localparam int PW    = (LOG + 1 > POS_W) ? LOG + 1 : POS_W;
   localparam int DW    = (LOG + 1 > 1) ? $clog2(LOG + 1) : 1;

   // node stores
   logic [PEND_W-1:0] pend_mem [NODES];
   logic [SUM_W-1:0]  cs_mem   [NODES];
   logic [PEND_W-1:0] pend_rd_ff;
   logic [SUM_W-1:0]  cs_rd_ff;

   // request and walk registers
   logic                    func_ff;
   logic [PW-1:0]           l_ff, r_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [NB-1:0]           k_ff, clr_ff;
   logic [PW-1:0]           lo_ff;
   logic [DW-1:0]           d_ff;
   logic signed [ACC_W-1:0] acc_ff, prod_ff, prod_in;
   logic                    ovf_ff;
   logic [SUM_W-1:0]        rsp_sum_ff;
   logic                    rsp_ovf_ff;

   logic [NB-1:0]           rd_addr, wr_addr;
   logic [DW-1:0]           sh_self, sh_child;
   logic [PW-1:0]           span, hi, ovl_min, ovl_max, ovl;
   logic signed [PEND_W+PW:0] part_prod;
   logic signed [PEND_W:0]  pend_sum;
   logic signed [ACC_W-1:0] fix_sum;
   logic                    acc_fits, fix_fits, pend_ovf;

   function automatic logic signed [ACC_W-1:0] node_value(
      input logic [PEND_W-1:0] p,
      input logic [SUM_W-1:0]  c,
      input logic [DW-1:0]     sh
   );
      logic signed [ACC_W-1:0] pv;
      logic signed [ACC_W-1:0] cv;
      pv = ACC_W'(signed'(p)) <<< sh;
      cv = ACC_W'(signed'(c));
      return pv + cv;
   endfunction

   function automatic logic fits_sum(input logic signed [ACC_W-1:0] v);
      return (&v[ACC_W-1:SUM_W-1]) | ~(|v[ACC_W-1:SUM_W-1]);
   endfunction

   // node geometry
   assign sh_self  = DW'(LOG) - d_ff;
   assign sh_child = DW'(LOG) - d_ff - DW'(1);
   assign span     = PW'(1) << sh_self;
   assign hi       = lo_ff + span;
   assign ovl_min  = (r_ff < hi) ? r_ff : hi;
   assign ovl_max  = (l_ff > lo_ff) ? l_ff : lo_ff;
   assign ovl      = ovl_min - ovl_max;

   // arithmetic
   assign part_prod = $signed(pend_rd_ff) * $signed({1'b0, ovl});
   assign pend_sum  = (PEND_W + 1)'(signed'(pend_rd_ff)) + (PEND_W + 1)'(val_ff);
   assign pend_ovf  = pend_sum[PEND_W] ^ pend_sum[PEND_W-1];
   assign fix_sum   = prod_ff + node_value(pend_rd_ff, cs_rd_ff, sh_child);
   assign fix_fits  = fits_sum(fix_sum);
   assign acc_fits  = fits_sum(acc_ff);

   always_comb begin
      prod_in = prod_ff;
      if (cmd.prod_full) prod_in = node_value(pend_rd_ff, cs_rd_ff, sh_self);
      if (cmd.prod_part) prod_in = ACC_W'(part_prod);
      if (cmd.prod_fix)  prod_in = node_value(pend_rd_ff, cs_rd_ff, sh_child);
   end

   // memory addresses
   always_comb begin
      unique case (cmd.rd_sel)
         RD_SELF:  rd_addr = k_ff;
         RD_LEFT:  rd_addr = {k_ff[NB-2:0], 1'b0};
         RD_RIGHT: rd_addr = {k_ff[NB-2:0], 1'b1};
         default:  rd_addr = k_ff;
      endcase
   end
   assign wr_addr = cmd.clear ? clr_ff : k_ff;

   // memory ports
   always_ff @(posedge clock) begin
      if (cmd.clear || cmd.wr_pend)
         pend_mem[wr_addr] <= cmd.clear ? '0 : pend_sum[PEND_W-1:0];
      if (cmd.clear || cmd.wr_cs)
         cs_mem[wr_addr] <= cmd.clear ? '0 : fix_sum[SUM_W-1:0];
      pend_rd_ff <= pend_mem[rd_addr];
      cs_rd_ff   <= cs_mem[rd_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + NB'(1);
         if ((cmd.wr_pend && pend_ovf) || (cmd.wr_cs && !fix_fits) ||
             (cmd.rsp_load && !acc_fits))
            ovf_ff <= 1'b1;
      end
   end

   // request capture and walk position
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         l_ff    <= PW'(req_range_start);
         r_ff    <= PW'(req_range_end);
         val_ff  <= req_add_value;
         k_ff    <= NB'(1);
         lo_ff   <= '0;
         d_ff    <= '0;
         acc_ff  <= '0;
      end else begin
         if (cmd.acc_add) acc_ff <= acc_ff + prod_ff;
         if (cmd.descend) begin
            k_ff <= {k_ff[NB-2:0], 1'b0};
            d_ff <= d_ff + DW'(1);
         end else if (cmd.sibling) begin
            k_ff  <= k_ff + NB'(1);
            lo_ff <= lo_ff + span;
         end else if (cmd.ascend) begin
            k_ff  <= k_ff >> 1;
            d_ff  <= d_ff - DW'(1);
            lo_ff <= lo_ff - span;
         end
      end
      prod_ff <= prod_in;
      if (cmd.rsp_load) begin
         rsp_sum_ff <= acc_ff[SUM_W-1:0];
         rsp_ovf_ff <= ovf_ff | ~acc_fits;
      end
   end

   // status
   assign status.empty    = (r_ff <= l_ff);
   assign status.disjoint = (r_ff <= lo_ff) || (hi <= l_ff);
   assign status.full     = (l_ff <= lo_ff) && (hi <= r_ff);
   assign status.is_root  = (k_ff == NB'(1));
   assign status.is_right = k_ff[0];
   assign status.is_query = (func_ff == FUNC_SUM);
   assign status.clr_last = &clr_ff;

   assign rsp_range_sum = signed'(rsp_sum_ff);
   assign rsp_overflow  = rsp_ovf_ff;
endmodule
`default_nettype wire

// ===== verif/range_add_range_sum_tree_core_checker.sv =====
// checker: segment tree predictor and response comparison for the range sum tree core
`timescale 1ns / 100ps
`default_nettype none
module range_add_range_sum_tree_core_checker #(
   parameter int LEAVES = 1024
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire                                req_func,
   input  wire [rarst_pkg::POS_W-1:0]         req_range_start,
   input  wire [rarst_pkg::POS_W-1:0]         req_range_end,
   input  wire signed [rarst_pkg::VAL_W-1:0]  req_add_value,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire signed [rarst_pkg::SUM_W-1:0]  rsp_range_sum,
   input  wire                                rsp_overflow,
   output int                                 fail_count,
   output int                                 pending_count
);
   import rarst_pkg::*;

   localparam int NODES = 2 * LEAVES;

   typedef struct packed {
      logic [SUM_W-1:0] range_sum;
      logic             overflow;
   } tree_answer_type;

   // model copy of the node store
   logic signed [PEND_W-1:0] pend_add[NODES];
   logic signed [SUM_W-1:0]  kid_sum[NODES];
   bit                       ovf_flag;
   tree_answer_type          answer_q[$];

   function automatic bit fits_48(longint v);
      return v >= -(64'sd1 <<< 47) && v <= ((64'sd1 <<< 47) - 1);
   endfunction

   function automatic longint node_value(int k, longint span);
      if (k < 1 || k >= NODES) return 0;
      return longint'(pend_add[k]) * span + longint'(kid_sum[k]);
   endfunction

   function automatic longint span_sum(int k, longint l, longint r, longint lo, longint hi);
      longint mid, a, b, ov_lo, ov_hi;
      if (r <= lo || hi <= l || r <= l || k < 1 || k >= NODES) return 0;
      if (l <= lo && hi <= r) return node_value(k, hi - lo);
      mid = lo + (hi - lo) / 2;
      a = span_sum(2 * k, l, r, lo, mid);
      b = span_sum(2 * k + 1, l, r, mid, hi);
      ov_hi = (r < hi) ? r : hi;
      ov_lo = (l > lo) ? l : lo;
      return longint'(pend_add[k]) * (ov_hi - ov_lo) + a + b;
   endfunction

   function automatic void span_add(int k, longint l, longint r, longint lo, longint hi,
                                    longint val);
      longint mid, t;
      if (r <= lo || hi <= l || r <= l || k < 1 || k >= NODES) return;
      if (l <= lo && hi <= r) begin
         t = longint'(pend_add[k]) + val;
         if (t < -(64'sd1 <<< 31) || t > ((64'sd1 <<< 31) - 1)) ovf_flag = 1;
         pend_add[k] = t[PEND_W-1:0];
         return;
      end
      mid = lo + (hi - lo) / 2;
      span_add(2 * k, l, r, lo, mid, val);
      span_add(2 * k + 1, l, r, mid, hi, val);
      t = node_value(2 * k, mid - lo) + node_value(2 * k + 1, hi - mid);
      if (!fits_48(t)) ovf_flag = 1;
      kid_sum[k] = t[SUM_W-1:0];
   endfunction

   // predict on each accepted request, compare each accepted response
   always @(posedge clock) begin
      tree_answer_type want;
      longint s;
      if (reset) begin
         for (int i = 0; i < NODES; i++) begin
            pend_add[i] = '0;
            kid_sum[i]  = '0;
         end
         ovf_flag = 0;
         answer_q.delete();
         fail_count    <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answer_q.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response sum=%0d ovf=%0b", rsp_range_sum, rsp_overflow);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_q.pop_front();
               if (want.range_sum !== rsp_range_sum || want.overflow !== rsp_overflow) begin
                  if (fail_count < 10)
                     $display("mismatch: expected sum=%0d ovf=%0b, got sum=%0d ovf=%0b",
                              $signed(want.range_sum), want.overflow,
                              rsp_range_sum, rsp_overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            s = 0;
            if (req_func == FUNC_ADD) begin
               span_add(1, req_range_start, req_range_end, 0, LEAVES,
                        longint'(req_add_value));
            end else begin
               s = span_sum(1, req_range_start, req_range_end, 0, LEAVES);
               if (!fits_48(s)) ovf_flag = 1;
            end
            want.range_sum = s[SUM_W-1:0];
            want.overflow  = ovf_flag;
            answer_q.push_back(want);
         end
         pending_count <= answer_q.size();
      end
   end
endmodule
`default_nettype wire

// ===== verif/range_add_range_sum_tree_core_tb.sv =====
// testbench top: stimulus, flow control and verdict for the range sum tree core
`timescale 1ns / 100ps
`default_nettype none
module range_add_range_sum_tree_core_tb;
   import rarst_pkg::*;

   localparam int LEAVES = 1024;
   localparam int RANDOM_ITEMS = 960;

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic              req_func = 0;
   logic [POS_W-1:0]  req_range_start = '0;
   logic [POS_W-1:0]  req_range_end = '0;
   logic signed [VAL_W-1:0] req_add_value = '0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic signed [SUM_W-1:0] rsp_range_sum;
   logic              rsp_overflow;
   int                fail_count, pending_count;
   bit                calm_sender = 0, calm_receiver = 0;
   bit                hold_receiver = 0;
   int                sent_count = 0;

   range_add_range_sum_tree_core #(.LEAVES(LEAVES)) DUT (.*);

   range_add_range_sum_tree_core_checker #(.LEAVES(LEAVES)) checker_i (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // response side back pressure
   always @(posedge clock) begin
      if (reset || hold_receiver) rsp_ready <= 0;
      else rsp_ready <= calm_receiver ? 1'b1 : ($urandom_range(99) >= 23);
   end

   // one long receiver hold-off once 300 requests have been sent
   initial begin
      wait (sent_count == 300);
      hold_receiver = 1;
      repeat (3000) @(posedge clock);
      hold_receiver = 0;
   end

   // offer one request and wait for its acceptance; valid drops only on idle cycles
   task automatic send_request(logic f, int l, int r, int v);
      while (!calm_sender && $urandom_range(99) < 23) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid       <= 1;
      req_func        <= f;
      req_range_start <= l[POS_W-1:0];
      req_range_end   <= r[POS_W-1:0];
      req_add_value   <= v[VAL_W-1:0];
      do @(posedge clock); while (!req_ready);
      sent_count++;
   endtask

   task automatic drain_all();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      int l, r, w, v, k;
      repeat (5) @(posedge clock);
      reset <= 0;
      // directed extremes and special cases
      send_request(FUNC_SUM, 0, 1024, 0);
      send_request(FUNC_ADD, 0, 1024, 32767);
      send_request(FUNC_SUM, 0, 1024, 0);
      send_request(FUNC_ADD, 0, 1024, -32768);
      send_request(FUNC_ADD, 5, 5, 1234);
      send_request(FUNC_ADD, 9, 3, 1234);
      send_request(FUNC_SUM, 700, 2, 0);
      send_request(FUNC_ADD, 1024, 2047, 100);
      send_request(FUNC_SUM, 1500, 2047, 0);
      send_request(FUNC_ADD, 1000, 2047, 77);
      send_request(FUNC_SUM, 1000, 2047, 0);
      send_request(FUNC_ADD, 0, 1, -1);
      send_request(FUNC_SUM, 0, 1, 0);
      send_request(FUNC_SUM, 1023, 1024, 0);
      send_request(FUNC_ADD, 3, 777, 21845);
      send_request(FUNC_SUM, 2, 778, 0);
      send_request(FUNC_SUM, 0, 0, 0);
      req_valid <= 0;
      drain_all();
      // sender pause once the block is empty
      repeat (50) @(posedge clock);
      // random part; a calm stretch in the middle
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm_sender   = (n >= 450 && n < 600);
         calm_receiver = (n >= 450 && n < 600);
         k = $urandom_range(99);
         if (k < 8) begin
            l = $urandom_range(2047);
            r = $urandom_range(2047);
         end else if (k < 25) begin
            l = $urandom_range(1023);
            r = l + $urandom_range(3);
         end else begin
            l = $urandom_range(1024);
            r = $urandom_range(1024);
            if (r < l) begin w = l; l = r; r = w; end
         end
         v = $urandom_range(15) == 0 ? ($urandom_range(1) ? 32767 : -32768)
                                     : $signed(16'($urandom));
         send_request(1'($urandom_range(1)), l, r, v);
      end
      // push 70 full-range adds of the largest positive value onto the root's pending add
      for (int n = 0; n < 70000 / 1000; n++) begin
         send_request(FUNC_ADD, 0, 1024, 32767);
      end
      send_request(FUNC_SUM, 0, 1024, 0);
      send_request(FUNC_SUM, 17, 900, 0);
      req_valid <= 0;
      calm_receiver = 0;
      drain_all();
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rarst_pkg.sv
hw/rtl/rarst_ctrl.sv
hw/rtl/rarst_datapath.sv
hw/rtl/range_add_range_sum_tree_core.sv
verif/range_add_range_sum_tree_core_checker.sv
verif/range_add_range_sum_tree_core_tb.sv
